/* design/sine_cosine_taylor_assert.svh */
// Assertion macros shared by the sine and cosine evaluator.
`ifndef SINE_COSINE_TAYLOR_ASSERT_SVH
`define SINE_COSINE_TAYLOR_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define SCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define SCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/sct_pkg.sv */
// Types, operation codes and series coefficients of the sine and cosine evaluator.
package sct_pkg;

  // Number of series terms summed by the pipeline.
  localparam int TERMS     = 10;
  localparam int MAX_TERMS = 12;

  typedef logic signed [30:0] angle_t;  // Q3.28 radians
  typedef logic signed [31:0] coef_t;   // Q2.30
  typedef logic signed [31:0] acc_t;    // Horner accumulator
  typedef logic        [31:0] sq_t;     // angle squared, unsigned Q.27
  typedef logic signed [31:0] value_t;  // Q1.30 result

  localparam logic OP_SIN = 1'b0;
  localparam logic OP_COS = 1'b1;

  localparam value_t ONE_Q30     = 32'sd1073741824;
  localparam value_t NEG_ONE_Q30 = -32'sd1073741824;

  // (-1)^i/(2i)! in Q2.30, rounded to nearest.
  localparam coef_t COS_COEF [MAX_TERMS] = '{
    32'sd1073741824, -32'sd536870912, 32'sd44739243, -32'sd1491308,
    32'sd26631, -32'sd296, 32'sd2, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0
  };

  // (-1)^i/(2i+1)! in Q2.30, rounded to nearest.
  localparam coef_t SIN_COEF [MAX_TERMS] = '{
    32'sd1073741824, -32'sd178956971, 32'sd8947849, -32'sd213044,
    32'sd2959, -32'sd27, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0
  };

  // What travels between Horner steps.
  typedef struct packed {
    logic   op;
    angle_t x;
    sq_t    s;
    acc_t   acc;
  } hstage_t;

endpackage

/* design/sct_chan_if.sv */
// Valid/ready channel interfaces for angle beats and result beats.
interface sct_in_if;
  import sct_pkg::*;
  logic   valid;
  logic   ready;
  logic   operation;
  angle_t angle;
  modport source(output valid, operation, angle, input ready);
  modport sink(input valid, operation, angle, output ready);
endinterface

interface sct_out_if;
  import sct_pkg::*;
  logic   valid;
  logic   ready;
  value_t value;
  modport source(output valid, value, input ready);
  modport sink(input valid, value, output ready);
endinterface

/* design/sct_horner_step.sv */
// One Horner step: product register, then shift, coefficient add and saturation.
module sct_horner_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  sct_pkg::hstage_t up_data,
  input  sct_pkg::coef_t   coef_sin,
  input  sct_pkg::coef_t   coef_cos,
  output logic             dn_valid,
  input  logic             dn_ready,
  output sct_pkg::hstage_t dn_data
);
  import sct_pkg::*;

  logic               a_v_r;
  hstage_t            a_r;
  logic signed [63:0] prod_r;
  logic               b_v_r;
  hstage_t            b_r;

  logic               a_rdy;
  logic               b_rdy;
  logic signed [64:0] prod_w;
  coef_t              coef_w;
  logic signed [36:0] sum_w;
  acc_t               acc_nxt;
  hstage_t            b_nxt;

  assign b_rdy    = !b_v_r || dn_ready;
  assign a_rdy    = !a_v_r || b_rdy;
  assign up_ready = a_rdy;

  assign prod_w = up_data.acc * $signed({1'b0, up_data.s});

  // The product is at most 2^62 in magnitude, so bits 63:27 are its floor.
  assign coef_w = (a_r.op == OP_COS) ? coef_cos : coef_sin;
  assign sum_w  = prod_r[63:27] + 37'(coef_w);

  always_comb begin
    if (sum_w > 37'sd2147483647) begin
      acc_nxt = 32'sh7FFFFFFF;
    end else if (sum_w < -37'sd2147483648) begin
      acc_nxt = 32'sh80000000;
    end else begin
      acc_nxt = sum_w[31:0];
    end
  end

  // The second slot keeps the angle, square and selector and takes the new sum.
  always_comb begin
    b_nxt     = a_r;
    b_nxt.acc = acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v_r <= up_valid;
      end
      if (b_rdy) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && up_valid) begin
      a_r    <= up_data;
      prod_r <= prod_w[63:0];
    end
    if (b_rdy && a_v_r) begin
      b_r <= b_nxt;
    end
  end

  assign dn_valid = b_v_r;
  assign dn_data  = b_r;

endmodule

/* design/sine_cosine_taylor.sv */
// Beat path: front stage, a register pair per Horner step, sine multiply stage, output register.
// Throughput: one beat per cycle unless the output stalls; each Horner step owns its own multiplier.
// Every register slot moves when the slot after it is empty or moving, so bubbles close up
// and a stalled output holds the pipeline without loss or repetition.
// Reset (rst_n low at a clock edge) clears only the valid bits; data registers are not reset.
module sine_cosine_taylor (
  input logic clk,
  input logic rst_n,
  sct_in_if.sink    in_ch,
  sct_out_if.source out_ch
);
  import sct_pkg::*;
  `include "sine_cosine_taylor_assert.svh"

  // Front stage: square the angle as it is accepted.
  logic        f_v_r;
  logic        f_op_r;
  angle_t      f_x_r;
  logic [60:0] f_sq_r;
  logic        f_rdy;
  logic signed [61:0] sq_w;

  // Links between Horner steps; slot zero is fed by the front stage.
  logic    st_v   [TERMS];
  logic    st_rdy [TERMS];
  hstage_t st_d   [TERMS];

  // Sine multiply stage.
  logic               k1_v_r;
  logic               k1_op_r;
  acc_t               k1_acc_r;
  logic signed [62:0] k1_p_r;
  logic               k1_rdy;
  logic signed [62:0] k1_p_w;

  // Output register.
  logic               o_v_r;
  value_t             o_val_r;
  logic               o_rdy;
  logic signed [34:0] cand_w;
  value_t             val_nxt;

  // ---------------------------------------------------------------- front
  assign sq_w        = in_ch.angle * in_ch.angle;
  assign f_rdy       = !f_v_r || st_rdy[0];
  assign in_ch.ready = f_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (f_rdy) begin
      f_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_rdy && in_ch.valid) begin
      f_op_r <= in_ch.operation;
      f_x_r  <= in_ch.angle;
      f_sq_r <= sq_w[60:0];
    end
  end

  // The square is at most 2^60, so dropping 29 fraction bits leaves a 32-bit Q.27 value.
  // The accumulator starts at the highest-order coefficient of the chosen series.
  assign st_v[0]     = f_v_r;
  assign st_d[0].op  = f_op_r;
  assign st_d[0].x   = f_x_r;
  assign st_d[0].s   = f_sq_r[60:29];
  assign st_d[0].acc = (f_op_r == OP_COS) ? COS_COEF[TERMS-1] : SIN_COEF[TERMS-1];

  // ---------------------------------------------------------------- Horner chain
  // Step k folds in coefficient TERMS-2-k, so the last step adds the constant term.
  for (genvar k = 0; k < TERMS - 1; k++) begin : g_step
    sct_horner_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_v[k]),
      .up_ready (st_rdy[k]),
      .up_data  (st_d[k]),
      .coef_sin (SIN_COEF[TERMS-2-k]),
      .coef_cos (COS_COEF[TERMS-2-k]),
      .dn_valid (st_v[k+1]),
      .dn_ready (st_rdy[k+1]),
      .dn_data  (st_d[k+1])
    );
  end

  // ---------------------------------------------------------------- sine multiply
  // For sine the even series is multiplied once more by the angle. The product is
  // computed for both selections; the output stage picks what it needs.
  assign k1_p_w             = st_d[TERMS-1].acc * st_d[TERMS-1].x;
  assign k1_rdy             = !k1_v_r || o_rdy;
  assign st_rdy[TERMS-1]    = k1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_v_r <= 1'b0;
    end else if (k1_rdy) begin
      k1_v_r <= st_v[TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (k1_rdy && st_v[TERMS-1]) begin
      k1_op_r  <= st_d[TERMS-1].op;
      k1_acc_r <= st_d[TERMS-1].acc;
      k1_p_r   <= k1_p_w;
    end
  end

  // ---------------------------------------------------------------- output
  // Bits 62:28 of the product are its floor after removing 28 fraction bits.
  // Either candidate is then saturated to plus or minus one in Q1.30.
  assign cand_w = (k1_op_r == OP_COS) ? 35'(k1_acc_r) : k1_p_r[62:28];

  always_comb begin
    if (cand_w > 35'(ONE_Q30)) begin
      val_nxt = ONE_Q30;
    end else if (cand_w < 35'(NEG_ONE_Q30)) begin
      val_nxt = NEG_ONE_Q30;
    end else begin
      val_nxt = cand_w[31:0];
    end
  end

  assign o_rdy = !o_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_rdy) begin
      o_v_r <= k1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && k1_v_r) begin
      o_val_r <= val_nxt;
    end
  end

  assign out_ch.valid = o_v_r;
  assign out_ch.value = o_val_r;

  // ---------------------------------------------------------------- checks
  `SCT_ASSERT_NEXT(a_in_lands, in_ch.valid && f_rdy, f_v_r, "accepted beat missing from front stage")
  `SCT_ASSERT_NEXT(a_front_holds, f_v_r && !st_rdy[0], f_v_r && $stable(f_x_r) && $stable(f_sq_r), "front stage changed while stalled")
  `SCT_ASSERT_NOW(a_out_range, o_v_r, (o_val_r <= ONE_Q30) && (o_val_r >= NEG_ONE_Q30), "result outside plus or minus one")

endmodule

/* verif/tb_sine_cosine_taylor.sv */
// Self-checking testbench for the sine and cosine Taylor series evaluator.
module tb_sine_cosine_taylor;
  import sct_pkg::*;

  // Pipeline depth from an angle beat to its result beat.
  localparam int PIPE_LATENCY = 2 * TERMS + 1;

  // The series length is held to the coefficient table, 1 to 12 terms.
  localparam int SERIES_LEN = (TERMS > 12) ? 12 : ((TERMS < 1) ? 1 : TERMS);

  // A run ends as failed after this many cycles in a row with no beat on either side.
  // The slowest legal stretch is a full pipeline plus the longest gap and stall.
  localparam int STALL_LIMIT = 4000;

  // Directed angles, Q3.28 radians.
  localparam angle_t PI_Q28      = 31'sd843314857;
  localparam angle_t HALF_PI_Q28 = 31'sd421657428;
  localparam angle_t ONE_RAD_Q28 = 31'sd268435456;
  localparam angle_t ANGLE_MAX   = 31'sd1073741823;
  localparam angle_t ANGLE_MIN   = -31'sd1073741824;

  // Saturation bounds of the Horner accumulator and of the final value.
  localparam longint ACC_HI = 64'sd2147483647;
  localparam longint ACC_LO = -64'sd2147483648;
  localparam longint VAL_HI = 64'sd1073741824;
  localparam longint VAL_LO = -64'sd1073741824;

  // Series coefficients in Q2.30, rounded to nearest: (-1)^i/(2i)! for cosine and
  // (-1)^i/(2i+1)! for sine. The high-order terms round to zero and stay zero.
  localparam longint COS_TAB [12] = '{
    64'sd1073741824, -64'sd536870912, 64'sd44739243, -64'sd1491308,
    64'sd26631, -64'sd296, 64'sd2, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0
  };
  localparam longint SIN_TAB [12] = '{
    64'sd1073741824, -64'sd178956971, 64'sd8947849, -64'sd213044,
    64'sd2959, -64'sd27, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0
  };

  // Idle styles shared by the sender and the receiver. A burst style never idles,
  // a sparse style idles now and then, and a choppy style may idle before every beat.
  localparam int IDLE_BURST  = 0;
  localparam int IDLE_CHOPPY = 1;
  localparam int IDLE_SPARSE = 2;

  // One pending angle beat. A hold entry carries no angle: it makes the sender
  // wait until every outstanding result has come back.
  typedef struct {
    logic        op;
    angle_t      angle;
    int unsigned gap;
    bit          hold;
  } angle_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  sct_in_if  angle_ch ();
  sct_out_if value_ch ();

  sine_cosine_taylor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (angle_ch),
    .out_ch (value_ch)
  );

  angle_beat_t pending_angles[$];
  value_t      expected_values[$];

  int          errors = 0;
  int          quiet_cycles = 0;
  int unsigned gap_count = 0;
  int unsigned stall_left = 0;
  int unsigned values_seen = 0;
  int          sink_style = IDLE_BURST;
  bit          angle_taken = 1'b0;
  bit          value_taken = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Expected result of one angle beat. The square and every Horner product are
  // floored, which an arithmetic right shift of a signed 64-bit value does exactly.
  // All products are at most 2^62 in magnitude, so nothing overflows before the saturation.
  function automatic value_t taylor_value(logic op, angle_t ang);
    longint x;
    longint sq;
    longint acc;
    longint coef;
    x   = longint'(ang);
    sq  = (x * x) >>> 29;
    acc = (op == OP_COS) ? COS_TAB[SERIES_LEN - 1] : SIN_TAB[SERIES_LEN - 1];
    for (int i = SERIES_LEN - 2; i >= 0; i--) begin
      coef = (op == OP_COS) ? COS_TAB[i] : SIN_TAB[i];
      acc  = ((acc * sq) >>> 27) + coef;
      if (acc > ACC_HI) begin
        acc = ACC_HI;
      end else if (acc < ACC_LO) begin
        acc = ACC_LO;
      end
    end
    // Sine carries one more factor of the angle; cosine is the sum itself.
    if (op == OP_SIN) begin
      acc = (acc * x) >>> 28;
    end
    if (acc > VAL_HI) begin
      acc = VAL_HI;
    end else if (acc < VAL_LO) begin
      acc = VAL_LO;
    end
    return value_t'(acc);
  endfunction

  // Number of idle cycles ahead of one beat, drawn at random by the given style.
  function automatic int unsigned draw_wait(int style);
    if (style == IDLE_BURST) begin
      return 0;
    end else if (style == IDLE_SPARSE) begin
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Random angle. Most lie within plus or minus pi, where the series is meant to
  // be used. Some cover the whole Q3.28 field, and the rest sit near pi, the field's ends or zero.
  function automatic angle_t random_angle();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      return angle_t'(int'($urandom_range(0, 2 * 843314857)) - 843314857);
    end else if (pick < 92) begin
      return angle_t'($urandom);
    end
    case ($urandom_range(0, 5))
      0: begin
        return PI_Q28 - angle_t'($urandom_range(0, 31));
      end
      1: begin
        return -PI_Q28 + angle_t'($urandom_range(0, 31));
      end
      2: begin
        return ANGLE_MAX - angle_t'($urandom_range(0, 31));
      end
      3: begin
        return ANGLE_MIN + angle_t'($urandom_range(0, 31));
      end
      4: begin
        return PI_Q28 + angle_t'($urandom_range(1, 1 << 20));
      end
      default: begin
        return angle_t'(int'($urandom_range(0, 64)) - 32);
      end
    endcase
  endfunction

  task automatic queue_angle(logic op, angle_t ang, int style);
    angle_beat_t beat;
    beat.op    = op;
    beat.angle = ang;
    beat.gap   = draw_wait(style);
    beat.hold  = 1'b0;
    pending_angles.push_back(beat);
  endtask

  task automatic queue_hold();
    angle_beat_t beat;
    beat.op    = OP_SIN;
    beat.angle = '0;
    beat.gap   = 0;
    beat.hold  = 1'b1;
    pending_angles.push_back(beat);
  endtask

  // Sender. It works at the falling edge, so each input is stable well before the
  // rising edge that may take it. The valid line is written once per edge: it stays
  // high from one beat into the next when the next beat has no gap.
  always @(negedge clk) begin : drive_angles
    logic        next_valid;
    angle_beat_t head;
    next_valid = angle_ch.valid;
    if (rst_n) begin
      if (angle_taken) begin
        next_valid  = 1'b0;
        angle_taken = 1'b0;
      end
      if (!next_valid && pending_angles.size() > 0) begin
        if (pending_angles[0].hold) begin
          // Let the pipeline run dry before the sender resumes.
          if (expected_values.size() == 0) begin
            void'(pending_angles.pop_front());
          end
        end else if (gap_count < pending_angles[0].gap) begin
          gap_count++;
        end else begin
          head               = pending_angles.pop_front();
          gap_count          = 0;
          angle_ch.operation <= head.op;
          angle_ch.angle     <= head.angle;
          next_valid         = 1'b1;
        end
      end
    end
    angle_ch.valid <= next_valid;
  end

  // Receiver. After every result beat it draws a stall and holds ready low for that
  // many cycles. Its idle style is drawn anew every 128 results, so stretches with no
  // stalls mix with sparse and choppy ones.
  always @(negedge clk) begin : drive_ready
    if (rst_n) begin
      if (value_taken) begin
        value_taken = 1'b0;
        values_seen++;
        if (values_seen % 128 == 0) begin
          sink_style = $urandom_range(IDLE_BURST, IDLE_SPARSE);
        end
        stall_left = draw_wait(sink_style);
      end
      if (stall_left > 0) begin
        stall_left--;
        value_ch.ready <= 1'b0;
      end else begin
        value_ch.ready <= 1'b1;
      end
    end
  end

  // Both channels are sampled at the rising edge. The result side is checked before
  // the angle side records its expectation, so a result can never be matched with
  // an angle taken at the same edge.
  always @(posedge clk) begin : watch_channels
    value_t want;
    if (rst_n) begin
      if (value_ch.valid && value_ch.ready) begin
        value_taken = 1'b1;
        if (expected_values.size() == 0) begin
          errors++;
          $display("%0t: value expected none actual %0d", $time, value_ch.value);
        end else begin
          want = expected_values.pop_front();
          if (value_ch.value !== want) begin
            errors++;
            $display("%0t: value expected %0d actual %0d", $time, want, value_ch.value);
          end
        end
      end
      if (angle_ch.valid && angle_ch.ready) begin
        angle_taken = 1'b1;
        expected_values.push_back(taylor_value(angle_ch.operation, angle_ch.angle));
      end
    end
  end

  // Watchdog. Any beat on either side restarts the count.
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((angle_ch.valid && angle_ch.ready) || (value_ch.valid && value_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("sine_cosine_taylor: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    angle_t corner [11];
    int     send_style;

    // Every input is known from the first instant.
    rst_n              = 1'b0;
    angle_ch.valid     = 1'b0;
    angle_ch.operation = OP_SIN;
    angle_ch.angle     = '0;
    value_ch.ready     = 1'b0;

    // Directed part: zero, the smallest steps, plus and minus pi and pi/2, one
    // radian, an angle beyond pi, and both ends of the Q3.28 field, for sine and
    // cosine alike.
    corner = '{'0, 31'sd1, -31'sd1, PI_Q28, -PI_Q28, HALF_PI_Q28, -HALF_PI_Q28,
               ONE_RAD_Q28, PI_Q28 + 31'sd1, ANGLE_MAX, ANGLE_MIN};
    foreach (corner[k]) begin
      queue_angle(OP_SIN, corner[k], IDLE_CHOPPY);
      queue_angle(OP_COS, corner[k], IDLE_BURST);
    end
    queue_hold();

    // Random part. The sender draws its idle style anew every 125 beats and starts
    // with a burst, and twice it pauses until the pipeline has drained.
    send_style = IDLE_BURST;
    for (int k = 0; k < 1750; k++) begin
      if (k > 0 && k % 125 == 0) begin
        send_style = $urandom_range(IDLE_BURST, IDLE_SPARSE);
      end
      if (k == 600 || k == 1200) begin
        queue_hold();
      end
      queue_angle(logic'($urandom_range(0, 1)), random_angle(), send_style);
    end

    // Reset is held low from time zero and released at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_angles.size() != 0 || angle_ch.valid) begin
      @(posedge clk);
    end
    while (expected_values.size() != 0) begin
      @(posedge clk);
    end
    // Leave room for any stray result that the block might still emit.
    repeat (PIPE_LATENCY + 8) @(posedge clk);

    if (errors == 0) begin
      $display("sine_cosine_taylor: match");
    end else begin
      $display("sine_cosine_taylor: mismatch");
    end
    $finish;
  end

endmodule
